>>> rtl/core/subarray_sums_divisible_count_assert.svh
// assertion macros for the subarray divisible-sum counter
// both sample on i_clk and stay off while i_rst_n is low
`ifndef SUBARRAY_SUMS_DIVISIBLE_COUNT_ASSERT_SVH
`define SUBARRAY_SUMS_DIVISIBLE_COUNT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sdc_pkg.sv
`default_nettype none

package sdc_pkg;

    // field widths
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 48;
    localparam int COUNT_W = 32;
    localparam int REM_W   = 10;
    localparam int CFG_W   = 11;

    // table size and sequence tag width
    localparam int MAX_DIVISOR_DEFAULT = 1024;
    localparam int TAG_W               = 8;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_step;
        logic div_step;
        logic fix;
        logic read;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic wrap_needed;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/core/sdc_if.sv
`default_nettype none

// input beat: one array element and its start flag
interface sdc_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [sdc_pkg::VALUE_W-1:0] value;
    logic                              start_sequence;

    modport source (output valid, output value, output start_sequence, input ready);
    modport sink   (input valid, input value, input start_sequence, output ready);
endinterface

// output beat: running total and prefix remainder
interface sdc_out_if;
    logic                       valid;
    logic                       ready;
    logic [sdc_pkg::TOTAL_W-1:0] subarray_total;
    logic [sdc_pkg::REM_W-1:0]   prefix_remainder;

    modport source (output valid, output subarray_total, output prefix_remainder,
                    input ready);
    modport sink   (input valid, input subarray_total, input prefix_remainder,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/sdc_ctrl.sv
`default_nettype none

module sdc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire sdc_pkg::t_status i_status,
    output sdc_pkg::t_cmd         o_cmd
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_WRAP   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_FIX    = 7'b0010000,
        S_READ   = 7'b0100000,
        S_COMMIT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.wrap_needed ? S_WRAP : S_DIV;
                end
            end
            S_WRAP: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sdc_datapath.sv
`default_nettype none

module sdc_datapath #(
    parameter int MAX_DIVISOR = sdc_pkg::MAX_DIVISOR_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [sdc_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  wire logic signed [sdc_pkg::VALUE_W-1:0] i_value,
    input  wire logic                               i_start,
    input  wire sdc_pkg::t_cmd                      i_cmd,
    output sdc_pkg::t_status                        o_status,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [sdc_pkg::TOTAL_W-1:0]             o_total,
    output logic [sdc_pkg::REM_W-1:0]               o_rem
);

    localparam int RW    = (MAX_DIVISOR > 1) ? $clog2(MAX_DIVISOR) : 1;
    localparam int DVW   = $clog2(MAX_DIVISOR + 1);
    localparam int DW    = sdc_pkg::VALUE_W + 1;
    localparam int SUM_W = sdc_pkg::VALUE_W + 2;
    localparam int CNT_W = $clog2(DW);

    typedef struct packed {
        logic [sdc_pkg::TAG_W-1:0]   tag;
        logic [sdc_pkg::COUNT_W-1:0] count;
    } t_entry;

    // remainder count table, tagged with the sequence it belongs to
    t_entry mem [MAX_DIVISOR];
    t_entry r_rd;

    // control state
    logic [sdc_pkg::CFG_W-1:0]   r_div;
    logic [sdc_pkg::TAG_W-1:0]   r_epoch;
    logic [RW-1:0]               r_clr_addr;
    logic                        r_zero_fresh;
    logic [RW-1:0]               r_rem;
    logic [sdc_pkg::TOTAL_W-1:0] r_total;
    logic                        r_out_valid;

    // payload state
    logic [DW-1:0]               r_mag;
    logic                        r_neg;
    logic [DVW-1:0]              r_d;
    logic [DVW-1:0]              r_prem;
    logic [CNT_W-1:0]            r_cnt;
    logic [RW-1:0]               r_idx;
    logic [sdc_pkg::TOTAL_W-1:0] r_out_total;
    logic [sdc_pkg::REM_W-1:0]   r_out_rem;

    logic [RW-1:0]               base;
    logic [SUM_W-1:0]            sum;
    logic [SUM_W-1:0]            mag_full;
    logic [31:0]                 cfg32;
    logic [31:0]                 eff32;
    logic [DVW:0]                p;
    logic [DVW:0]                dd;
    logic [DVW:0]                p_red;
    logic [DVW-1:0]              fixed_rem;
    logic [sdc_pkg::COUNT_W-1:0] seen;
    logic [sdc_pkg::COUNT_W-1:0] count_next;
    logic [sdc_pkg::TOTAL_W:0]   total_sum;
    logic [sdc_pkg::TOTAL_W-1:0] n_total;
    logic [31:0]                 rem32;
    logic                        clr_last;
    logic                        we;
    logic [RW-1:0]               waddr;
    t_entry                      wdata;

    // prefix sum magnitude and sign for the divider
    always_comb begin
        base     = i_start ? '0 : r_rem;
        sum      = {{2{i_value[sdc_pkg::VALUE_W-1]}}, i_value} + SUM_W'(base);
        mag_full = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
    end

    // effective divisor, zero taken as one, clamped to the table size
    always_comb begin
        cfg32 = 32'(r_div);
        if (r_div == '0) begin
            eff32 = 32'd1;
        end else if (cfg32 > 32'(MAX_DIVISOR)) begin
            eff32 = 32'(MAX_DIVISOR);
        end else begin
            eff32 = cfg32;
        end
    end

    // one restoring remainder step per cycle
    always_comb begin
        p     = {r_prem, r_mag[DW-1]};
        dd    = {1'b0, r_d};
        p_red = (p >= dd) ? (p - dd) : p;
    end

    // floor remainder from the truncated one
    assign fixed_rem = (r_neg && (r_prem != '0)) ? (r_d - r_prem) : r_prem;

    // table lookup result, saturating updates
    always_comb begin
        if (r_zero_fresh && (r_idx == '0)) begin
            seen = sdc_pkg::COUNT_W'(1);
        end else if (r_rd.tag == r_epoch) begin
            seen = r_rd.count;
        end else begin
            seen = '0;
        end
        count_next = (&seen) ? seen : (seen + 1'b1);
        total_sum  = {1'b0, r_total} + (sdc_pkg::TOTAL_W + 1)'(seen);
        n_total    = total_sum[sdc_pkg::TOTAL_W] ? '1 : total_sum[sdc_pkg::TOTAL_W-1:0];
        rem32      = 32'(r_idx);
    end

    // table write port: clearing sweep or commit
    always_comb begin
        clr_last = (r_clr_addr == RW'(MAX_DIVISOR - 1));
        we       = i_cmd.clr_step | i_cmd.commit;
        waddr    = i_cmd.clr_step ? r_clr_addr : r_idx;
        if (i_cmd.clr_step) begin
            wdata = '0;
        end else begin
            wdata.tag   = r_epoch;
            wdata.count = count_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.read) begin
            r_rd <= mem[r_idx];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div        <= sdc_pkg::CFG_W'(1);
            r_epoch      <= sdc_pkg::TAG_W'(1);
            r_clr_addr   <= '0;
            r_zero_fresh <= 1'b0;
            r_rem        <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_div <= i_cfg_wr_data;
            end
            // clearing sweep, tags restart after it
            if (i_cmd.clr_step) begin
                if (clr_last) begin
                    r_clr_addr <= '0;
                    r_epoch    <= sdc_pkg::TAG_W'(1);
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            // new sequence: fresh tag, empty prefix counted once
            if (i_cmd.load && i_start) begin
                r_total      <= '0;
                r_zero_fresh <= 1'b1;
                if (!(&r_epoch)) begin
                    r_epoch <= r_epoch + 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_total <= n_total;
                r_rem   <= r_idx;
                if (r_idx == '0) begin
                    r_zero_fresh <= 1'b0;
                end
            end
            // output register
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag  <= mag_full[DW-1:0];
            r_neg  <= sum[SUM_W-1];
            r_d    <= eff32[DVW-1:0];
            r_prem <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_mag  <= {r_mag[DW-2:0], 1'b0};
            r_prem <= p_red[DVW-1:0];
            r_cnt  <= r_cnt + 1'b1;
        end
        if (i_cmd.fix) begin
            r_idx <= fixed_rem[RW-1:0];
        end
        if (i_cmd.commit) begin
            r_out_total <= n_total;
            r_out_rem   <= rem32[sdc_pkg::REM_W-1:0];
        end
    end

    // status
    always_comb begin
        o_status.clr_last    = clr_last;
        o_status.div_last    = (r_cnt == CNT_W'(DW - 1));
        o_status.wrap_needed = i_start && (&r_epoch);
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_total     = r_out_total;
    assign o_rem       = r_out_rem;

endmodule

`default_nettype wire

>>> rtl/core/subarray_sums_divisible_count.sv
// Counts subarrays whose sum is divisible by a configured divisor, one element a beat.
// i_in carries a signed 32-bit element and a start flag that opens a new array;
// o_out returns the running subarray total (saturating) and the prefix remainder.
// i_cfg_wr_en/i_cfg_wr_data write the divisor (zero acts as one, larger values
// clamp to MAX_DIVISOR); write it only while no beat is in flight.
// A new input beat is taken only once the previous beat has been committed to
// the output register. The remainder unit resolves one bit of the 33-bit
// prefix sum magnitude per cycle; sign fix, table read and table update follow
// in that order.
// Reset (synchronous, active low) starts a clearing pass over all MAX_DIVISOR
// entries of the count table; i_in.ready stays low until it ends. Each sequence
// gets an 8-bit tag; every 255th start beat after that triggers another pass
// over the table before its element is worked on.
// The result sits in an output register; if the receiver stalls, the next beat
// is still taken and worked on, and waits for the register to drain before
// its table update.
`default_nettype none

module subarray_sums_divisible_count #(
    parameter int MAX_DIVISOR = sdc_pkg::MAX_DIVISOR_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [sdc_pkg::CFG_W-1:0] i_cfg_wr_data,
    sdc_in_if.sink                         i_in,
    sdc_out_if.source                      o_out
);

    sdc_pkg::t_cmd    cmd;
    sdc_pkg::t_status status;
    logic             in_ready;

    // sequencer
    sdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // remainder unit, count table and output register
    sdc_datapath #(
        .MAX_DIVISOR (MAX_DIVISOR)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_value       (i_in.value),
        .i_start       (i_in.start_sequence),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_total       (o_out.subarray_total),
        .o_rem         (o_out.prefix_remainder)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

>>> rtl/core/sdc_checker.sv
`default_nettype none

`include "subarray_sums_divisible_count_assert.svh"

module sdc_checker #(
    parameter int MAX_DIVISOR = sdc_pkg::MAX_DIVISOR_DEFAULT
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_cfg_wr_en,
    input wire logic [sdc_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [sdc_pkg::TOTAL_W-1:0] i_out_total,
    input wire logic [sdc_pkg::REM_W-1:0]   i_out_rem
);

    logic [sdc_pkg::CFG_W-1:0]                   r_div;
    logic [31:0]                                 eff_div;
    logic                                        out_stall;
    logic [sdc_pkg::TOTAL_W+sdc_pkg::REM_W-1:0]  out_payload;

    // shadow of the divisor register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= sdc_pkg::CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            r_div <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_div == '0) begin
            eff_div = 32'd1;
        end else if (32'(r_div) > 32'(MAX_DIVISOR)) begin
            eff_div = 32'(MAX_DIVISOR);
        end else begin
            eff_div = 32'(r_div);
        end
    end

    // stalled output beat and its payload
    assign out_stall   = i_out_valid && !i_out_ready;
    assign out_payload = {i_out_total, i_out_rem};

    // output beat held while stalled
    `SDC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "output beat dropped")
    `SDC_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_payload), "stalled output changed")

    // remainder below the divisor in force
    `SDC_ASSERT_SAME(a_rem_range, i_out_valid, 32'(i_out_rem) < eff_div, "remainder not reduced")

    // one element at a time: input closes after a beat is taken
    `SDC_ASSERT_NEXT(a_in_close, i_in_valid && i_in_ready, !i_in_ready, "input open right after beat")

endmodule

bind subarray_sums_divisible_count sdc_checker #(
    .MAX_DIVISOR (MAX_DIVISOR)
) u_sdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_total   (o_out.subarray_total),
    .i_out_rem     (o_out.prefix_remainder)
);

`default_nettype wire

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TABLE_SIZE  = sdc_pkg::MAX_DIVISOR_DEFAULT;
    localparam longint TOTAL_LIMIT = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint COUNT_LIMIT = 64'h0000_0000_FFFF_FFFF;
    localparam int     HOLD_CYCLES = 400;
    localparam int     TAIL_CYCLES = 40;

    // one result beat as the block returns it
    typedef struct packed {
        logic [sdc_pkg::TOTAL_W-1:0] subarray_total;
        logic [sdc_pkg::REM_W-1:0]   prefix_remainder;
    } t_sum_count;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [sdc_pkg::CFG_W-1:0] i_cfg_wr_data;

    sdc_in_if  in_bus ();
    sdc_out_if out_bus ();

    subarray_sums_divisible_count uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_bus),
        .o_out         (out_bus)
    );

    // predictor state: divisor, prefix remainder, total and remainder table
    logic [sdc_pkg::CFG_W-1:0]   modulus_setting;
    logic [sdc_pkg::REM_W-1:0]   prefix_rem;
    longint                      running_total;
    bit [sdc_pkg::COUNT_W-1:0]   slot_count [TABLE_SIZE];
    bit [TABLE_SIZE-1:0]         slot_valid;

    t_sum_count awaited_counts [$];
    int         error_count;
    bit         steady_flow;
    int         hold_req_id;
    int         hold_seen_id;
    int         hold_left;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // divisor as the block applies it
    function automatic longint effective_modulus();
        if (modulus_setting == 0) return 1;
        if (modulus_setting > TABLE_SIZE) return TABLE_SIZE;
        return longint'(modulus_setting);
    endfunction

    // next prefix remainder, table lookup and saturating total update
    task automatic predict_divisible_step(input logic signed [31:0] value,
                                          input logic start, output t_sum_count result);
        longint modulus;
        longint prefix;
        longint slot;
        longint seen;
        modulus = effective_modulus();
        if (start) begin
            slot_valid    = '0;
            slot_valid[0] = 1'b1;
            slot_count[0] = 1;
            prefix_rem    = '0;
            running_total = 0;
        end
        prefix = longint'(prefix_rem) + longint'(value);
        slot = prefix % modulus;
        if (slot < 0) slot += modulus;
        prefix_rem = 10'(slot);
        seen = slot_valid[slot] ? longint'(slot_count[slot]) : 0;
        if (running_total + seen > TOTAL_LIMIT) running_total = TOTAL_LIMIT;
        else running_total = running_total + seen;
        slot_count[slot] = (seen == COUNT_LIMIT) ? 32'hFFFF_FFFF : 32'(seen + 1);
        slot_valid[slot] = 1'b1;
        result.subarray_total   = 48'(running_total);
        result.prefix_remainder = prefix_rem;
    endtask

    // random element: full range, small, extremes or near a multiple of k
    function automatic logic signed [31:0] pick_element();
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3, 4, 5: return int'($urandom_range(64)) - 32;
            6: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return -1;
                    default: return 0;
                endcase
            end
            default: return int'(effective_modulus()) * (int'($urandom_range(20)) - 10)
                            + int'($urandom_range(2)) - 1;
        endcase
    endfunction

    // send one input beat, with random idle cycles ahead of it unless steady_flow is set
    task automatic send_element(input logic signed [31:0] value, input logic start);
        t_sum_count want;
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < 33) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid          <= 1'b1;
        in_bus.value          <= value;
        in_bus.start_sequence <= start;
        do @(posedge i_clk); while (!(in_bus.valid && in_bus.ready));
        predict_divisible_step(value, start, want);
        awaited_counts.push_back(want);
    endtask

    // stop offering beats and wait for every expected result
    task automatic wait_drained();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (awaited_counts.size() != 0) @(posedge i_clk);
    endtask

    // divisor write, only while nothing is in flight
    task automatic write_divisor(input logic [sdc_pkg::CFG_W-1:0] setting);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= setting;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        modulus_setting = setting;
    endtask

    // no start flag yet: empty prefix not counted
    task automatic test_empty_table_after_reset();
        send_element(5, 1'b0);
        send_element(-7, 1'b0);
        send_element(0, 1'b0);
    endtask

    // value extremes under the largest divisor
    task automatic test_field_extremes();
        write_divisor(11'd1024);
        send_element(32'h7FFF_FFFF, 1'b1);
        send_element(32'h8000_0000, 1'b0);
        send_element(-1, 1'b0);
        send_element(0, 1'b0);
        send_element(1, 1'b0);
        send_element(1023, 1'b0);
        send_element(-1024, 1'b0);
        send_element(32'h8000_0000, 1'b1);
    endtask

    // zero divisor, clamped divisors and negative normalization
    task automatic test_divisor_limits();
        write_divisor(11'd0);
        send_element(32'h8000_0000, 1'b1);
        send_element(12345, 1'b0);
        write_divisor(11'd2047);
        send_element(32'h7FFF_FFFF, 1'b1);
        send_element(-3, 1'b0);
        write_divisor(11'd1025);
        send_element(1024, 1'b0);
        send_element(-1, 1'b0);
        write_divisor(11'd1);
        send_element(-99, 1'b0);
        write_divisor(11'd3);
        send_element(-1, 1'b1);
        send_element(-2, 1'b0);
        send_element(4, 1'b0);
    endtask

    // stored remainder reduced again under a new divisor
    task automatic test_divisor_change_mid_array();
        write_divisor(11'd1000);
        send_element(999, 1'b1);
        send_element(500, 1'b0);
        write_divisor(11'd7);
        send_element(3, 1'b0);
        send_element(-10, 1'b0);
    endtask

    // long receiver hold-off fills the block, then sender waits for drain
    task automatic test_backpressure();
        write_divisor(11'd6);
        hold_req_id++;
        for (int i = 0; i < 24; i++) send_element(pick_element(), i == 0);
        wait_drained();
        for (int i = 0; i < 6; i++) send_element(pick_element(), 1'b0);
    endtask

    // enough start beats to wrap the sequence tag
    task automatic test_tag_wrap();
        write_divisor(11'd13);
        for (int i = 0; i < 260; i++) send_element(pick_element(), 1'b1);
    endtask

    // well-formed arrays with random content over many divisors
    task automatic test_random_streams();
        logic [sdc_pkg::CFG_W-1:0] phase_divisors [12] =
            '{11'd1, 11'd2, 11'd3, 11'd5, 11'd16, 11'd100, 11'd1023, 11'd1024,
              11'd0, 11'd2047, 11'd1500, 11'd0};
        int  remaining;
        int  run_len;
        bit  open_new;
        for (int p = 0; p < 12; p++) begin
            if (p == 11) phase_divisors[p] = 11'($urandom_range(2047));
            write_divisor(phase_divisors[p]);
            steady_flow = (p == 4);
            // first array of a phase may carry on from the previous divisor
            open_new = (p == 0) || ($urandom_range(1) == 0);
            remaining = 80;
            while (remaining > 0) begin
                run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 30)
                                                   : $urandom_range(12, 1);
                for (int i = 0; i < run_len && remaining > 0; i++) begin
                    if (i == 0) send_element(pick_element(), open_new);
                    else send_element(pick_element(), $urandom_range(29) == 0);
                    remaining--;
                end
                open_new = 1'b1;
            end
            steady_flow = 1'b0;
        end
    endtask

    // receiver: random stalls, plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_req_id != hold_seen_id) begin
            hold_seen_id <= hold_req_id;
            hold_left    <= HOLD_CYCLES;
            out_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= steady_flow || ($urandom_range(99) >= 33);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_beat
        t_sum_count want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (awaited_counts.size() == 0) begin
                $display("%0t: unexpected result beat, total %0d remainder %0d", $time,
                         out_bus.subarray_total, out_bus.prefix_remainder);
                error_count++;
            end else begin
                want = awaited_counts.pop_front();
                if (out_bus.subarray_total !== want.subarray_total) begin
                    $display("%0t: subarray_total expected %0d, got %0d", $time,
                             want.subarray_total, out_bus.subarray_total);
                    error_count++;
                end
                if (out_bus.prefix_remainder !== want.prefix_remainder) begin
                    $display("%0t: prefix_remainder expected %0d, got %0d", $time,
                             want.prefix_remainder, out_bus.prefix_remainder);
                    error_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #9_600_000;
        $display("DONE: errors detected");
        $finish;
    end

    // reset, test sequence and final verdict
    initial begin
        i_rst_n               = 1'b0;
        i_cfg_wr_en           = 1'b0;
        i_cfg_wr_data         = '0;
        in_bus.valid          = 1'b0;
        in_bus.value          = '0;
        in_bus.start_sequence = 1'b0;
        out_bus.ready         = 1'b0;
        error_count           = 0;
        steady_flow           = 1'b0;
        hold_req_id           = 0;
        hold_seen_id          = 0;
        hold_left             = 0;
        modulus_setting       = 11'd1;
        prefix_rem            = '0;
        running_total         = 0;
        slot_valid            = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table_after_reset();
        test_field_extremes();
        test_divisor_limits();
        test_divisor_change_mid_array();
        test_backpressure();
        test_tag_wrap();
        test_random_streams();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sdc_pkg.sv
rtl/core/sdc_if.sv
rtl/core/sdc_ctrl.sv
rtl/core/sdc_datapath.sv
rtl/core/subarray_sums_divisible_count.sv
rtl/core/sdc_checker.sv
tb/sv/testbench.sv
